// ===== design/preemptive_priority_tick_scheduler_top_macros.svh =====
// Assertion helpers used by the scheduler datapath.
`ifndef PREEMPTIVE_PRIORITY_TICK_SCHEDULER_TOP_MACROS_SVH
`define PREEMPTIVE_PRIORITY_TICK_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pps_pkg.sv =====
package pps_pkg;

	localparam logic [15:0] TIME_MAX = 16'hFFFF;

	// Command codes of a request.
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  slot;
		logic [15:0] burst_len;
		logic [15:0] arrival;
		logic [7:0]  prio;
	} req_t;

	typedef struct packed {
		logic        ran;
		logic [3:0]  run_slot;
		logic        finished;
		logic [15:0] finish_time;
		logic [15:0] turnaround;
		logic [15:0] waiting;
		logic        all_done;
	} rsp_t;

	// One task record as held in the task memory.
	typedef struct packed {
		logic [15:0] arrive;
		logic [15:0] burst;
		logic [15:0] left;
		logic [7:0]  prio;
	} task_rec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_LAST,
		ST_COMMIT,
		ST_SETTLE,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic exec;
		logic scan;
		logic commit;
		logic settle;
		logic resp_load;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cmd_tick;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage

// ===== design/pps_chan_if.sv =====
interface pps_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/preemptive_priority_tick_scheduler_top.sv =====
// Preemptive priority tick scheduler.
// Requests arrive on req (valid/ready); each carries a command: clear the
// task table and time, load a task into a slot, or advance one tick.
// Every request yields exactly one response on rsp (valid/ready) with the
// slot that ran, completion data when a task finished, the current time,
// and a flag that is set when no loaded task has time left.
// A tick reads the task memory one slot per cycle through its single read
// port while the best ready task is tracked, then the chosen task is
// written back and its times are worked out. Clear, load and unused
// commands skip the scan. One request is in flight at a time: a new one
// is accepted only once the previous result is in the output register.
// The response sits in an output register; a new request is accepted
// while it waits, and the block holds that request's response until the
// receiver takes the previous one. A stalled receiver never loses data.
// Reset clears the time and marks every slot empty; no clearing pass is
// needed and requests are taken from the first cycle after reset.
module preemptive_priority_tick_scheduler_top #(
	parameter int TASKS = 16
) (
	input logic       clk,
	input logic       arst_n,
	pps_chan_if.sink   req,
	pps_chan_if.source rsp
);

	pps_pkg::ctl_t  ctl;
	pps_pkg::stat_t stat;

	// Sequencer.
	pps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.stat      (stat),
		.req_ready (req.ready),
		.ctl       (ctl)
	);

	// Task table, selection and result datapath.
	pps_dp #(
		.TASKS (TASKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.req_data  (req.data),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.data),
		.stat      (stat)
	);

endmodule

// ===== design/pps_ctrl.sv =====
module pps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  pps_pkg::stat_t stat,
	output logic           req_ready,
	output pps_pkg::ctl_t  ctl
);

	pps_pkg::state_t state_q;
	pps_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			pps_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.take = 1'b1;
					state_d  = pps_pkg::ST_EXEC;
				end
			end
			pps_pkg::ST_EXEC: begin
				if (stat.cmd_tick) begin
					state_d = pps_pkg::ST_SCAN;
				end else begin
					ctl.exec = 1'b1;
					state_d  = pps_pkg::ST_RESP;
				end
			end
			pps_pkg::ST_SCAN: begin
				ctl.scan = 1'b1;
				if (stat.scan_last) begin
					state_d = pps_pkg::ST_LAST;
				end
			end
			pps_pkg::ST_LAST: begin
				state_d = pps_pkg::ST_COMMIT;
			end
			pps_pkg::ST_COMMIT: begin
				ctl.commit = 1'b1;
				state_d    = pps_pkg::ST_SETTLE;
			end
			pps_pkg::ST_SETTLE: begin
				ctl.settle = 1'b1;
				state_d    = pps_pkg::ST_RESP;
			end
			pps_pkg::ST_RESP: begin
				if (stat.out_free) begin
					ctl.resp_load = 1'b1;
					state_d       = pps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pps_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/pps_dp.sv =====
`include "preemptive_priority_tick_scheduler_top_macros.svh"

module pps_dp #(
	parameter int TASKS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pps_pkg::ctl_t  ctl,
	input  pps_pkg::req_t  req_data,
	input  logic           rsp_ready,
	output logic           rsp_valid,
	output pps_pkg::rsp_t  rsp_data,
	output pps_pkg::stat_t stat
);

	localparam int SW = $clog2(TASKS);
	localparam logic [8:0] TASKS_W = 9'(TASKS);
	localparam logic [SW-1:0] LAST_IDX = SW'(TASKS - 1);

	pps_pkg::task_rec_t mem [TASKS];

	pps_pkg::req_t      req_q;
	logic [15:0]        now_q;
	logic [TASKS-1:0]   live_q;
	logic [SW-1:0]      idx_q;
	logic               rd_vld_s1;
	logic [SW-1:0]      rd_idx_s1;
	pps_pkg::task_rec_t rd_rec_s1;
	logic               found_q;
	logic [SW-1:0]      best_idx_q;
	pps_pkg::task_rec_t best_rec_q;
	logic               res_ran_q;
	logic [3:0]         res_slot_q;
	logic               res_fin_q;
	logic [15:0]        res_turn_q;
	logic [15:0]        res_wait_q;
	logic               out_valid_q;
	pps_pkg::rsp_t      out_q;

	logic               load_ok;
	logic [SW-1:0]      load_idx;
	logic               cand_ready;
	logic               cand_better;
	logic [15:0]        now_inc;
	logic [15:0]        left_dec;
	logic               wr_en;
	logic [SW-1:0]      wr_addr;
	pps_pkg::task_rec_t wr_data;

	assign load_ok  = (9'(req_q.slot) < TASKS_W);
	assign load_idx = SW'(req_q.slot);
	assign now_inc  = (now_q == pps_pkg::TIME_MAX) ? now_q : now_q + 16'd1;
	assign left_dec = best_rec_q.left - 16'd1;

	assign stat.cmd_tick  = (req_q.command == pps_pkg::CMD_TICK);
	assign stat.scan_last = (idx_q == LAST_IDX);
	assign stat.out_free  = !out_valid_q || rsp_ready;

	// Capture the request.
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			req_q <= req_data;
		end
	end

	// Task memory: one write port, one registered read port for the scan.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_idx_q;
		wr_data = best_rec_q;
		if (ctl.exec && req_q.command == pps_pkg::CMD_LOAD && load_ok) begin
			wr_en          = 1'b1;
			wr_addr        = load_idx;
			wr_data.arrive = req_q.arrival;
			wr_data.burst  = req_q.burst_len;
			wr_data.left   = req_q.burst_len;
			wr_data.prio   = req_q.prio;
		end else if (ctl.commit && found_q) begin
			wr_en        = 1'b1;
			wr_data.left = left_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan) begin
			rd_rec_s1 <= mem[idx_q];
			rd_idx_s1 <= idx_q;
		end
	end

	// Scan counter and read-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= ctl.scan;
			if (ctl.take) begin
				idx_q <= '0;
			end else if (ctl.scan) begin
				idx_q <= idx_q + SW'(1);
			end
		end
	end

	// Best-candidate selection; slots arrive in ascending order so ties keep the lower one.
	assign cand_ready  = live_q[rd_idx_s1] && (rd_rec_s1.arrive <= now_q);
	assign cand_better = cand_ready && (!found_q || (rd_rec_s1.prio < best_rec_q.prio) ||
		((rd_rec_s1.prio == best_rec_q.prio) && (rd_rec_s1.arrive < best_rec_q.arrive)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.take) begin
			found_q <= 1'b0;
		end else if (rd_vld_s1 && cand_better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && cand_better) begin
			best_idx_q <= rd_idx_s1;
			best_rec_q <= rd_rec_s1;
		end
	end

	// Time and per-slot "loaded with time left" flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q  <= '0;
			live_q <= '0;
		end else begin
			if (ctl.exec && req_q.command == pps_pkg::CMD_CLEAR) begin
				now_q  <= '0;
				live_q <= '0;
			end else if (ctl.exec && req_q.command == pps_pkg::CMD_LOAD && load_ok) begin
				live_q[load_idx] <= (req_q.burst_len != 16'd0);
			end else if (ctl.commit) begin
				now_q <= now_inc;
				if (found_q && left_dec == 16'd0) begin
					live_q[best_idx_q] <= 1'b0;
				end
			end
		end
	end

	// Result fields of the current request.
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			res_ran_q  <= 1'b0;
			res_slot_q <= '0;
			res_fin_q  <= 1'b0;
			res_turn_q <= '0;
			res_wait_q <= '0;
		end else if (ctl.commit) begin
			res_ran_q  <= found_q;
			res_slot_q <= found_q ? 4'(best_idx_q) : 4'd0;
			res_fin_q  <= found_q && (left_dec == 16'd0);
			res_turn_q <= (found_q && left_dec == 16'd0) ? now_inc - best_rec_q.arrive : 16'd0;
		end else if (ctl.settle) begin
			// Waiting saturates at zero when the time limit shortened the turnaround.
			res_wait_q <= (res_fin_q && res_turn_q >= best_rec_q.burst) ?
				res_turn_q - best_rec_q.burst : 16'd0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.resp_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.resp_load) begin
			out_q.ran         <= res_ran_q;
			out_q.run_slot    <= res_slot_q;
			out_q.finished    <= res_fin_q;
			out_q.finish_time <= now_q;
			out_q.turnaround  <= res_turn_q;
			out_q.waiting     <= res_wait_q;
			out_q.all_done    <= ~|live_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	`PPS_ASSERT_NOW(a_resp_into_free, clk, arst_n, ctl.resp_load, !out_valid_q || rsp_ready, "result overwrites a pending response")
	`PPS_ASSERT_NOW(a_best_is_live, clk, arst_n, found_q && (ctl.scan || rd_vld_s1), live_q[best_idx_q], "chosen slot has no time left")
	`PPS_ASSERT_NEXT(a_finish_clears, clk, arst_n, ctl.commit && found_q && left_dec == 16'd0, !live_q[$past(best_idx_q)], "finished slot still marked live")
	`PPS_ASSERT_NEXT(a_tick_advances, clk, arst_n, ctl.commit, now_q != 16'd0, "time did not advance on a tick")

endmodule

// ===== dv/schedule_checker.sv =====
// Watches both channels of the scheduler, keeps its own copy of the task
// table and the time, and compares every response with the one predicted
// for the oldest request still waiting.
module schedule_checker #(
	parameter int TASKS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  pps_pkg::req_t req_data,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  pps_pkg::rsp_t rsp_data,
	output int            mismatch_count,
	output int            queue_depth,
	output int            tick_count,
	output int            idle_count,
	output int            done_count
);

	// Shadow of the task table and the scheduler time.
	logic        live [TASKS];
	logic [15:0] arrive_at [TASKS];
	logic [15:0] burst_of [TASKS];
	logic [15:0] left_of [TASKS];
	logic [7:0]  rank [TASKS];
	logic [15:0] clock_now;

	// Responses predicted for accepted requests, oldest first.
	pps_pkg::rsp_t pending_results [$];

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	// Applies one request to the shadow table and returns its response.
	function automatic pps_pkg::rsp_t next_schedule_result(input pps_pkg::req_t r);
		pps_pkg::rsp_t o;
		int            best;
		logic          found;
		logic [15:0]   turn;
		o = '0;
		case (r.command)
			pps_pkg::CMD_CLEAR: begin
				for (int k = 0; k < TASKS; k++) live[k] = 1'b0;
				clock_now = '0;
			end
			pps_pkg::CMD_LOAD: begin
				// A slot beyond the table is dropped.
				if (int'(r.slot) < TASKS) begin
					live[r.slot] = 1'b1;
					arrive_at[r.slot] = r.arrival;
					burst_of[r.slot] = r.burst_len;
					left_of[r.slot] = r.burst_len;
					rank[r.slot] = r.prio;
				end
			end
			pps_pkg::CMD_TICK: begin
				// Most urgent ready task; ties go to the earlier arrival, then
				// to the lower slot because the scan only replaces on a strict win.
				found = 1'b0;
				best = 0;
				for (int k = 0; k < TASKS; k++) begin
					if (live[k] && left_of[k] != '0 && arrive_at[k] <= clock_now) begin
						if (!found || rank[k] < rank[best] ||
								(rank[k] == rank[best] && arrive_at[k] < arrive_at[best])) begin
							best = k;
							found = 1'b1;
						end
					end
				end
				// Time stops at its ceiling.
				if (clock_now != pps_pkg::TIME_MAX) clock_now = clock_now + 16'd1;
				tick_count++;
				if (!found) begin
					idle_count++;
				end else begin
					o.ran = 1'b1;
					o.run_slot = 4'(best);
					left_of[best] = left_of[best] - 16'd1;
					if (left_of[best] == '0) begin
						o.finished = 1'b1;
						turn = clock_now - arrive_at[best];
						o.turnaround = turn;
						// With the time pinned, turnaround can fall short of the burst.
						if (turn >= burst_of[best]) begin
							o.waiting = turn - burst_of[best];
						end else begin
							o.waiting = '0;
						end
						done_count++;
					end
				end
			end
			default: begin
			end
		endcase
		o.finish_time = clock_now;
		o.all_done = 1'b1;
		for (int k = 0; k < TASKS; k++) begin
			if (live[k] && left_of[k] != '0) o.all_done = 1'b0;
		end
		return o;
	endfunction

	task automatic compare_result(input pps_pkg::rsp_t got, input pps_pkg::rsp_t want);
		check_field("ran", 16'(got.ran), 16'(want.ran));
		check_field("run_slot", 16'(got.run_slot), 16'(want.run_slot));
		check_field("finished", 16'(got.finished), 16'(want.finished));
		check_field("finish_time", got.finish_time, want.finish_time);
		check_field("turnaround", got.turnaround, want.turnaround);
		check_field("waiting", got.waiting, want.waiting);
		check_field("all_done", 16'(got.all_done), 16'(want.all_done));
	endtask

	// A response always belongs to an earlier request, so it is matched first.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_results.delete();
			clock_now = '0;
			for (int k = 0; k < TASKS; k++) live[k] = 1'b0;
			mismatch_count = 0;
			tick_count = 0;
			idle_count = 0;
			done_count = 0;
			queue_depth <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("response with no request waiting");
				end else begin
					compare_result(rsp_data, pending_results.pop_front());
				end
			end
			if (req_valid && req_ready) begin
				pending_results.push_back(next_schedule_result(req_data));
			end
			queue_depth <= pending_results.size();
		end
	end

endmodule

// ===== dv/preemptive_priority_tick_scheduler_top_tb.sv =====
// Stimulus and verdict for the scheduler; checking lives in schedule_checker.
module preemptive_priority_tick_scheduler_top_tb;

	localparam int         PERIOD = 12;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int         RANDOM_ITEMS = 1760;
	localparam int         CALM_AFTER = 1460;
	localparam int         HOLD_AFTER = 400;
	localparam int         HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic calm;
	int   req_taken;
	int   sent;
	int   fail_count;
	int   queue_depth;
	int   tick_count;
	int   idle_count;
	int   done_count;

	pps_chan_if #(.T(pps_pkg::req_t)) req_if ();
	pps_chan_if #(.T(pps_pkg::rsp_t)) rsp_if ();

	preemptive_priority_tick_scheduler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	schedule_checker #(.TASKS(16)) sched_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_if.valid),
		.req_ready(req_if.ready),
		.req_data(req_if.data),
		.rsp_valid(rsp_if.valid),
		.rsp_ready(rsp_if.ready),
		.rsp_data(rsp_if.data),
		.mismatch_count(fail_count),
		.queue_depth(queue_depth),
		.tick_count(tick_count),
		.idle_count(idle_count),
		.done_count(done_count)
	);

	initial clk = 1'b0;
	always #(PERIOD / 2) clk = ~clk;

	// Accepted requests, used to time the long receiver hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_taken <= 0;
		end else if (req_if.valid && req_if.ready) begin
			req_taken <= req_taken + 1;
		end
	end

	// Receiver: random stall bursts, one long hold-off that backs the block up.
	initial begin : receiver
		logic held_off;
		held_off = 1'b0;
		rsp_if.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!held_off && req_taken >= HOLD_AFTER) begin
				held_off = 1'b1;
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Request with random don't-care fields and the given command.
	function automatic pps_pkg::req_t with_command(input logic [1:0] cmd);
		pps_pkg::req_t r;
		r.command = cmd;
		r.slot = 4'($urandom());
		r.burst_len = 16'($urandom());
		r.arrival = 16'($urandom());
		r.prio = 8'($urandom());
		return r;
	endfunction

	// Offers one request, sometimes after an idle burst, and waits for acceptance.
	task automatic offer(input pps_pkg::req_t r);
		if (!calm && $urandom_range(0, 6) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do @(posedge clk); while (!req_if.ready);
		sent++;
	endtask

	task automatic load(input int slot, input int burst, input int arrival, input int prio);
		pps_pkg::req_t r;
		r = with_command(pps_pkg::CMD_LOAD);
		r.slot = 4'(slot);
		r.burst_len = 16'(burst);
		r.arrival = 16'(arrival);
		r.prio = 8'(prio);
		offer(r);
	endtask

	task automatic tick_n(input int n);
		repeat (n) offer(with_command(pps_pkg::CMD_TICK));
	endtask

	// One schedule: clear, load a handful of tasks, tick to end the short ones,
	// with the odd newcomer, unused command or wholly random request mixed in.
	task automatic run_episode();
		int ntask;
		int budget;
		int last_arrival;
		int b;
		int a;
		offer(with_command(pps_pkg::CMD_CLEAR));
		ntask = $urandom_range(1, 6);
		budget = 0;
		last_arrival = 0;
		repeat (ntask) begin
			case ($urandom_range(0, 9))
				0: b = 0;
				1: b = $urandom_range(0, 65535);
				default: b = $urandom_range(1, 8);
			endcase
			a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
			load($urandom_range(0, 15), b, a,
				($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 255));
			if (b <= 8) budget += b;
			if (a <= 12 && a > last_arrival) last_arrival = a;
		end
		budget += last_arrival + $urandom_range(0, 3);
		while (budget > 0) begin
			case ($urandom_range(0, 29))
				0: begin
					// A late arrival that may preempt the running task.
					b = $urandom_range(1, 4);
					load($urandom_range(0, 15), b, $urandom_range(0, 20), $urandom_range(0, 255));
					budget += b;
				end
				1: offer(with_command(CMD_SPARE));
				2: offer(with_command(2'($urandom_range(0, 3))));
				default: begin
					offer(with_command(pps_pkg::CMD_TICK));
					budget--;
				end
			endcase
		end
	endtask

	initial begin : stimulus
		int start;
		arst_n = 1'b0;
		calm = 1'b0;
		sent = 0;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Idle tick on an empty table, then a zero-burst task that never runs.
		tick_n(1);
		load(15, 0, 0, 0);
		tick_n(1);
		// Equal priorities: earlier arrival beats lower slot, then lower slot wins;
		// slot 2 arrives later with top priority and preempts.
		load(3, 2, 0, 7);
		load(4, 2, 0, 7);
		load(1, 1, 1, 7);
		load(2, 1, 3, 0);
		offer(with_command(CMD_SPARE));
		tick_n(4);
		// Overwrite a partly run task with one that never arrives, add a long one.
		load(4, 1, 65535, 255);
		load(0, 65535, 0, 255);
		tick_n(3);
		// Clear, idle tick, and a task that finishes on its first tick.
		offer(with_command(pps_pkg::CMD_CLEAR));
		tick_n(1);
		load(7, 1, 0, 0);
		tick_n(1);

		// Random schedules; the final stretch runs without idling.
		start = sent;
		while (sent - start < RANDOM_ITEMS) begin
			if (sent - start >= CALM_AFTER) calm <= 1'b1;
			run_episode();
		end

		req_if.valid <= 1'b0;
		do @(posedge clk); while (queue_depth != 0);
		repeat (30) @(posedge clk);
		$display("Covered %0d requests: %0d ticks, %0d of them idle, %0d task completions.",
			req_taken, tick_count, idle_count, done_count);
		$display("Mixed in loads over running tasks, clears, unused commands and a long stall.");
		if (fail_count == 0) begin
			$display("preemptive_priority_tick_scheduler_top_tb passed");
		end else begin
			$display("preemptive_priority_tick_scheduler_top_tb failed");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#(PERIOD * 8_000_000);
		$display("Timed out with %0d responses outstanding.", queue_depth);
		$display("preemptive_priority_tick_scheduler_top_tb failed");
		$finish;
	end

endmodule
